FILE: rtl/p_square_quantile_estimator_assert.svh
// Assertion macros for the quantile estimator, clocked on aclk and disabled in reset.
`ifndef P_SQUARE_QUANTILE_ESTIMATOR_ASSERT_SVH
`define P_SQUARE_QUANTILE_ESTIMATOR_ASSERT_SVH

// Same-cycle implication.
`define PSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/psq_pkg.sv
// Package with widths, register indexes and sequencer states of the quantile estimator.
`default_nettype none
package psq_pkg;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int H_W              = 48;
    localparam int POS_W            = 32;
    localparam int DES_W            = 64;
    localparam int P_W              = 17;
    localparam int RAMP_W           = 16;
    localparam int CNT_W            = 32;
    localparam int CFG_IDX_W        = 1;
    localparam logic [P_W-1:0] P_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P_QUANTILE  = 1'b0,
        REG_WEIGHT_RAMP = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WDIV,
        ST_ADJ,
        ST_DIV1,
        ST_DIV0,
        ST_EST,
        ST_MUL,
        ST_BLEND,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/p_square_quantile_estimator.sv
// Top level of the streaming P-square quantile estimator with a shared serial divider.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_valid / s_ready     s_sample
//  m_       out        m_valid / m_ready     m_estimate, m_warmed_up, m_marker_*
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Warm-up samples are taken in the idle state (sorted insert into the warm-up buffer).
// Later samples run in order: accept, the weight division on the one restoring divider,
// a check of each inner marker and the load of the result; each marker that moves adds
// two divisions and three arithmetic steps (estimate, multiply, blend).
// Reset (synchronous, active low) clears the state, sample count and m_valid and presets p and ramp.
// s_ready needs the idle state and a free output register; cfg_ready is always high.
`default_nettype none
module p_square_quantile_estimator
    import psq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [H_W-1:0]              m_estimate,
    output logic                               m_warmed_up,
    output logic signed [H_W-1:0]              m_marker_min,
    output logic signed [H_W-1:0]              m_marker_low,
    output logic signed [H_W-1:0]              m_marker_high,
    output logic signed [H_W-1:0]              m_marker_max,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [P_W-1:0]                cfg_data
);
    `include "p_square_quantile_estimator_assert.svh"

    localparam int AW    = 56;
    localparam int QW    = AW - 16;
    localparam int DIV_W = 49;
    localparam int DEN_W = 32;
    localparam int DCW   = $clog2(DIV_W);
    localparam logic signed [63:0] HMAX = 64'sd140737488355327;
    localparam logic signed [63:0] HMIN = -HMAX - 64'sd1;
    localparam logic signed [63:0] HLIM = HMAX >>> FRAC_BITS;
    localparam logic [DES_W-1:0] ONE32 = 64'h1_0000_0000;

    // Saturating scale of a sample to the height format.
    function automatic logic signed [H_W-1:0] scale(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            if (v > HLIM) begin
                r = HMAX;
            end else if (v < -HLIM - 64'sd1) begin
                r = HMIN;
            end else begin
                r = v <<< FRAC_BITS;
            end
            return r[H_W-1:0];
        end
    endfunction

    // Signed shift by 16 with truncation toward zero.
    function automatic logic signed [AW-1:0] trunc16(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] b;
        begin
            b = x + (x < 0 ? AW'(65535) : AW'(0));
            return b >>> 16;
        end
    endfunction

    function automatic logic signed [AW-1:0] clampv(input logic signed [AW-1:0] lo,
                                                  input logic signed [AW-1:0] hi,
                                                  input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        begin
            y = (x > hi) ? hi : x;
            return (y < lo) ? lo : y;
        end
    endfunction

    function automatic logic [DES_W-1:0] sat_add(input logic [DES_W-1:0] a,
                                                 input logic [DES_W-1:0] b);
        logic [DES_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[DES_W] ? {DES_W{1'b1}} : s[DES_W-1:0];
        end
    endfunction

    // State and configuration registers.
    state_t state_reg, state_next;
    logic [P_W-1:0]    p_reg;
    logic [RAMP_W-1:0] ramp_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [SAMPLE_WIDTH-1:0] wbuf_reg [0:4];
    logic signed [SAMPLE_WIDTH-1:0] wbuf_next [0:4];
    logic signed [H_W-1:0] h_reg [0:4];
    logic signed [H_W-1:0] h_next [0:4];
    logic [POS_W-1:0] pos_reg [0:4];
    logic [POS_W-1:0] pos_next [0:4];
    logic [DES_W-1:0] des_reg [1:3];
    logic [DES_W-1:0] des_next [1:3];
    logic [P_W-1:0] w_reg, w_next;
    logic [1:0] k_reg, k_next;
    logic up_reg, up_next;
    logic signed [AW-1:0] t1_reg, t1_next, t0_reg, t0_next;
    logic signed [AW-1:0] diff_reg, diff_next, lin_reg, lin_next, qw_reg, qw_next;
    logic signed [34:0] rw_reg, rw_next;

    // Serial divider registers.
    logic [DIV_W-1:0] div_num_reg, div_num_next;
    logic [DEN_W:0]   div_rem_reg, div_rem_next;
    logic [DEN_W-1:0] div_den_reg, div_den_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic div_neg_reg, div_neg_next, div_zero_reg, div_zero_next;

    // Output register.
    logic m_valid_reg, m_valid_next, m_warm_reg, m_warm_next;
    logic signed [H_W-1:0] m_est_reg, m_est_next, m_min_reg, m_min_next;
    logic signed [H_W-1:0] m_low_reg, m_low_next, m_high_reg, m_high_next;
    logic signed [H_W-1:0] m_max_reg, m_max_next;

    // Shared combinational terms.
    logic accept;
    logic [P_W-1:0] p_eff;
    logic [RAMP_W-1:0] ramp_eff;
    logic signed [H_W-1:0] hs;
    logic [2:0] ins_pos;
    logic signed [SAMPLE_WIDTH-1:0] sorted [0:4];
    logic [19:0] idx_prod;
    logic [2:0] idx;
    logic [CNT_W-1:0] count_inc;
    logic signed [AW-1:0] qp, qc, qn;
    logic [POS_W-1:0] pp, pc, pn;
    logic [DES_W-1:0] des;
    logic signed [POS_W:0] g0, g1;
    logic up_c, down_c;
    logic [DEN_W:0] rem_sh;
    logic div_ge, div_last;
    logic signed [AW-1:0] div_result, num1, num0, mag1, mag0;
    logic signed [AW-1:0] t1s, t0s, tsum, est, lin, estc, blend;
    logic signed [QW-1:0] qdiv;
    logic signed [AW-1:0] rdiv;
    logic signed [QW+17:0] qw_prod;
    logic late_accept, early_accept, markers_ordered;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign p_eff     = (p_reg > P_ONE) ? P_ONE : p_reg;
    assign ramp_eff  = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
    assign hs        = scale(64'(s_sample));
    assign count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + CNT_W'(1);

    // Sorted insert of the new sample into the warm-up buffer.
    always_comb begin
        ins_pos = '0;
        for (int j = 0; j < 5; j++) begin
            if (CNT_W'(j) < count_reg && wbuf_reg[j] <= s_sample) begin
                ins_pos = ins_pos + 3'd1;
            end
        end
        for (int j = 0; j < 5; j++) begin
            if (3'(j) < ins_pos) begin
                sorted[j] = wbuf_reg[j];
            end else if (3'(j) == ins_pos) begin
                sorted[j] = s_sample;
            end else begin
                sorted[j] = wbuf_reg[(j > 0) ? j - 1 : 0];
            end
        end
        idx_prod = 20'(p_eff) * 20'(count_reg[2:0]) + 20'd32768;
        idx      = (idx_prod[19:16] > 4'(count_reg[2:0])) ? count_reg[2:0] : idx_prod[18:16];
    end

    // Neighbor selection for the inner marker under adjustment.
    always_comb begin
        unique case (k_reg)
            2'd2: begin
                qp = AW'(h_reg[1]); qc = AW'(h_reg[2]); qn = AW'(h_reg[3]);
                pp = pos_reg[1]; pc = pos_reg[2]; pn = pos_reg[3]; des = des_reg[2];
            end
            2'd3: begin
                qp = AW'(h_reg[2]); qc = AW'(h_reg[3]); qn = AW'(h_reg[4]);
                pp = pos_reg[2]; pc = pos_reg[3]; pn = pos_reg[4]; des = des_reg[3];
            end
            default: begin
                qp = AW'(h_reg[0]); qc = AW'(h_reg[1]); qn = AW'(h_reg[2]);
                pp = pos_reg[0]; pc = pos_reg[1]; pn = pos_reg[2]; des = des_reg[1];
            end
        endcase
        g0     = $signed({1'b0, pc}) - $signed({1'b0, pp});
        g1     = $signed({1'b0, pn}) - $signed({1'b0, pc});
        up_c   = ({1'b0, des[63:32]} >= {1'b0, pc} + 33'd1) && (g1 > 33'sd1);
        down_c = !up_c && (pc != '0) && (des <= {pc - 32'd1, 32'd0}) && (g0 > 33'sd1);
        num1   = qn - qc;
        num0   = qc - qp;
        mag1   = (num1 < 0) ? -num1 : num1;
        mag0   = (num0 < 0) ? -num0 : num0;
    end

    // One restoring divider step.
    always_comb begin
        rem_sh     = {div_rem_reg[DEN_W-1:0], div_num_reg[DIV_W-1]};
        div_ge     = rem_sh >= {1'b0, div_den_reg};
        div_last   = div_cnt_reg == DCW'(DIV_W - 1);
        div_result = AW'({div_num_reg[DIV_W-2:0], div_ge});
        if (div_zero_reg) begin
            div_result = '0;
        end else if (div_neg_reg) begin
            div_result = -div_result;
        end
    end

    // Estimate, blend and clamp arithmetic.
    always_comb begin
        t1s   = up_reg ? t1_reg : -t1_reg;
        t0s   = up_reg ? t0_reg : -t0_reg;
        tsum  = t1s + t0s;
        est   = qc + ((tsum + (tsum < 0 ? AW'(1) : AW'(0))) >>> 1);
        lin   = up_reg ? qc + t1_reg : qc - t0_reg;
        if (est <= qp || est >= qn) begin
            est = lin;
        end
        estc    = clampv(qp, qn, est);
        qdiv    = QW'(trunc16(diff_reg));
        rdiv    = diff_reg - (AW'(qdiv) <<< 16);
        qw_prod = (QW+18)'(qdiv) * $signed({1'b0, w_reg});
        blend   = clampv(qp, qn, lin_reg + qw_reg + trunc16(AW'(rw_reg)));
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && count_reg >= CNT_W'(5)) begin
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV: begin
                if (div_last) state_next = ST_ADJ;
            end
            ST_ADJ: begin
                if (up_c || down_c) begin
                    state_next = ST_DIV1;
                end else if (k_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV1: begin
                if (div_last) state_next = ST_DIV0;
            end
            ST_DIV0: begin
                if (div_last) state_next = ST_EST;
            end
            ST_EST:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_BLEND;
            ST_BLEND: state_next = (k_reg == 2'd3) ? ST_DONE : ST_ADJ;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and output next values.
    always_comb begin
        count_next = count_reg;
        for (int j = 0; j < 5; j++) begin
            wbuf_next[j] = wbuf_reg[j];
            h_next[j]    = h_reg[j];
            pos_next[j]  = pos_reg[j];
        end
        for (int j = 1; j < 4; j++) des_next[j] = des_reg[j];
        w_next = w_reg; k_next = k_reg; up_next = up_reg;
        t1_next = t1_reg; t0_next = t0_reg; diff_next = diff_reg; lin_next = lin_reg;
        qw_next = qw_reg; rw_next = rw_reg;
        div_num_next  = {div_num_reg[DIV_W-2:0], div_ge};
        div_rem_next  = div_ge ? rem_sh - {1'b0, div_den_reg} : rem_sh;
        div_cnt_next  = div_cnt_reg + DCW'(1);
        div_den_next  = div_den_reg;
        div_neg_next  = div_neg_reg;
        div_zero_next = div_zero_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_warm_next = m_warm_reg; m_est_next = m_est_reg; m_min_next = m_min_reg;
        m_low_next = m_low_reg; m_high_next = m_high_reg; m_max_next = m_max_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && count_reg < CNT_W'(5)) begin
                    // Warm-up: keep the buffer sorted and report the rank estimate, or the markers on the fifth.
                    for (int j = 0; j < 5; j++) wbuf_next[j] = sorted[j];
                    count_next   = count_reg + CNT_W'(1);
                    m_valid_next = 1'b1;
                    if (count_reg == CNT_W'(4)) begin
                        for (int j = 0; j < 5; j++) begin
                            h_next[j]   = scale(64'(sorted[j]));
                            pos_next[j] = POS_W'(j + 1);
                        end
                        des_next[1] = ONE32 + (DES_W'(p_eff) << 17);
                        des_next[2] = ONE32 + (DES_W'(p_eff) << 18);
                        des_next[3] = ONE32 + ((DES_W'(P_ONE) + DES_W'(p_eff)) << 17);
                        m_warm_next = 1'b1;
                        m_est_next  = scale(64'(sorted[2]));
                        m_min_next  = scale(64'(sorted[0]));
                        m_low_next  = scale(64'(sorted[1]));
                        m_high_next = scale(64'(sorted[3]));
                        m_max_next  = scale(64'(sorted[4]));
                    end else begin
                        m_warm_next = 1'b0;
                        m_est_next  = scale(64'(sorted[idx]));
                        m_min_next  = '0;
                        m_low_next  = '0;
                        m_high_next = '0;
                        m_max_next  = '0;
                    end
                end else if (accept) begin
                    // Move end markers and positions, advance desired positions, start the weight division.
                    count_next = count_inc;
                    if (hs < h_reg[0]) h_next[0] = hs;
                    if (hs >= h_reg[4]) h_next[4] = hs;
                    for (int j = 1; j < 5; j++) begin
                        if (hs < h_reg[j] && pos_reg[j] != {POS_W{1'b1}}) begin
                            pos_next[j] = pos_reg[j] + POS_W'(1);
                        end
                    end
                    des_next[1] = sat_add(des_reg[1], DES_W'(p_eff) << 15);
                    des_next[2] = sat_add(des_reg[2], DES_W'(p_eff) << 16);
                    des_next[3] = sat_add(des_reg[3],
                                          (DES_W'(P_ONE) + DES_W'(p_eff)) << 15);
                    div_num_next  = DIV_W'({count_inc, 16'd0});
                    div_den_next  = DEN_W'(ramp_eff);
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                    div_neg_next  = 1'b0;
                    div_zero_next = 1'b0;
                end
            end
            ST_WDIV: begin
                if (div_last) begin
                    w_next = (AW'(div_result) > AW'(P_ONE)) ? P_ONE : div_result[P_W-1:0];
                    k_next = 2'd1;
                end
            end
            ST_ADJ: begin
                if (up_c || down_c) begin
                    up_next       = up_c;
                    div_num_next  = mag1[DIV_W-1:0];
                    div_den_next  = g1[DEN_W-1:0];
                    div_neg_next  = num1 < 0;
                    div_zero_next = g1 <= 33'sd0;
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_DIV1: begin
                if (div_last) begin
                    t1_next       = div_result;
                    div_num_next  = mag0[DIV_W-1:0];
                    div_den_next  = g0[DEN_W-1:0];
                    div_neg_next  = num0 < 0;
                    div_zero_next = g0 <= 33'sd0;
                    div_rem_next  = '0;
                    div_cnt_next  = '0;
                end
            end
            ST_DIV0: begin
                if (div_last) t0_next = div_result;
            end
            ST_EST: begin
                diff_next = estc - lin;
                lin_next  = lin;
            end
            ST_MUL: begin
                qw_next = qw_prod[AW-1:0];
                rw_next = 35'(rdiv) * 35'($signed({1'b0, w_reg}));
            end
            ST_BLEND: begin
                // Write back the adjusted inner marker.
                unique case (k_reg)
                    2'd2: begin
                        h_next[2]   = blend[H_W-1:0];
                        pos_next[2] = up_reg ? pc + POS_W'(1) : pc - POS_W'(1);
                    end
                    2'd3: begin
                        h_next[3]   = blend[H_W-1:0];
                        pos_next[3] = up_reg ? pc + POS_W'(1) : pc - POS_W'(1);
                    end
                    default: begin
                        h_next[1]   = blend[H_W-1:0];
                        pos_next[1] = up_reg ? pc + POS_W'(1) : pc - POS_W'(1);
                    end
                endcase
                k_next = k_reg + 2'd1;
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                m_warm_next  = 1'b1;
                m_est_next   = h_reg[2];
                m_min_next   = h_reg[0];
                m_low_next   = h_reg[1];
                m_high_next  = h_reg[3];
                m_max_next   = h_reg[4];
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            p_reg       <= 17'd32768;
            ramp_reg    <= 16'd100;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_P_QUANTILE:  p_reg    <= cfg_data;
                    REG_WEIGHT_RAMP: ramp_reg <= cfg_data[RAMP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < 5; j++) begin
            wbuf_reg[j] <= wbuf_next[j];
            h_reg[j]    <= h_next[j];
            pos_reg[j]  <= pos_next[j];
        end
        for (int j = 1; j < 4; j++) des_reg[j] <= des_next[j];
        w_reg <= w_next; k_reg <= k_next; up_reg <= up_next;
        t1_reg <= t1_next; t0_reg <= t0_next; diff_reg <= diff_next;
        lin_reg <= lin_next; qw_reg <= qw_next; rw_reg <= rw_next;
        div_num_reg <= div_num_next; div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next; div_cnt_reg <= div_cnt_next;
        div_neg_reg <= div_neg_next; div_zero_reg <= div_zero_next;
        m_warm_reg <= m_warm_next; m_est_reg <= m_est_next; m_min_reg <= m_min_next;
        m_low_reg <= m_low_next; m_high_reg <= m_high_next; m_max_reg <= m_max_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_warmed_up   = m_warm_reg;
    assign m_estimate    = m_est_reg;
    assign m_marker_min  = m_min_reg;
    assign m_marker_low  = m_low_reg;
    assign m_marker_high = m_high_reg;
    assign m_marker_max  = m_max_reg;

    // Terms watched by the assertions.
    assign late_accept     = accept && count_reg >= CNT_W'(5);
    assign early_accept    = accept && count_reg < CNT_W'(4);
    assign markers_ordered = m_marker_min <= m_marker_low && m_marker_low <= m_estimate &&
                             m_estimate <= m_marker_high && m_marker_high <= m_marker_max;

    // A sample after warm-up keeps the block busy on the following cycle.
    `PSQ_ASSERT_NEXT(a_busy_after_accept, late_accept, !s_ready, "second transaction taken")
    // A warm-up sample before the fifth gives a result at once, not warmed up.
    `PSQ_ASSERT_NEXT(a_warmup_result, early_accept, m_valid && !m_warmed_up, "no warm-up result")
    // Active markers stay in order.
    `PSQ_ASSERT_NOW(a_marker_order, m_valid && m_warmed_up, markers_ordered, "markers out of order")
endmodule
`default_nettype wire

FILE: test/tb_p_square_quantile_estimator.sv
// Self-checking testbench for the streaming P-square quantile estimator.
module tb_p_square_quantile_estimator;
    import psq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;

    typedef struct {
        logic [H_W-1:0] est;
        logic           warm;
        logic [H_W-1:0] mmin;
        logic [H_W-1:0] mlow;
        logic [H_W-1:0] mhigh;
        logic [H_W-1:0] mmax;
    } quantile_result_t;

    typedef struct {
        logic signed [31:0] sample;
        bit                 typed;
        logic [H_W-1:0]     est;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_sample;
    logic m_valid;
    logic m_ready;
    logic signed [H_W-1:0] m_estimate;
    logic m_warmed_up;
    logic signed [H_W-1:0] m_marker_min;
    logic signed [H_W-1:0] m_marker_low;
    logic signed [H_W-1:0] m_marker_high;
    logic signed [H_W-1:0] m_marker_max;
    logic cfg_valid;
    logic cfg_ready;
    cfg_reg_t cfg_index;
    logic [P_W-1:0] cfg_data;

    // Predictor state.
    longint unsigned   q_p;
    longint unsigned   q_ramp;
    longint            q_buf [5];
    int unsigned       q_count;
    longint            q_h [5];
    int unsigned       q_pos [5];
    longint unsigned   q_des [5];

    quantile_result_t  pending_results [$];
    int                errors;
    int                cycles;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_request;

    p_square_quantile_estimator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate),
        .m_warmed_up   (m_warmed_up),
        .m_marker_min  (m_marker_min),
        .m_marker_low  (m_marker_low),
        .m_marker_high (m_marker_high),
        .m_marker_max  (m_marker_max),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_height(longint lo, longint hi, longint x);
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x;
    endfunction

    function automatic longint gap_slope(longint num, longint gap);
        return (gap > 0) ? num / gap : 64'sd0;
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        return (a > ~64'd0 - b) ? ~64'd0 : a + b;
    endfunction

    // Move inner marker k toward its desired position with a blended estimate.
    function automatic void move_marker(int k, longint wt);
        longint qp, qc, qn, pp, pc, pn, g0, g1, t0, t1, est, slope, lin, diff, blend;
        longint unsigned des;
        bit up, down;
        qp = q_h[k-1]; qc = q_h[k]; qn = q_h[k+1];
        pp = q_pos[k-1]; pc = q_pos[k]; pn = q_pos[k+1];
        des = q_des[k];
        g0 = pc - pp;
        g1 = pn - pc;
        up = ((des >> 32) >= longint'(pc) + 1) && g1 > 1;
        down = !up && pc >= 1 && des <= (longint'(pc - 1) << 32) && g0 > 1;
        if (!up && !down) return;
        t1 = gap_slope(qn - qc, g1);
        t0 = gap_slope(qc - qp, g0);
        if (down) begin
            t1 = -t1;
            t0 = -t0;
        end
        est = qc + (t1 + t0) / 2;
        slope = up ? gap_slope(qn - qc, g1) : gap_slope(qc - qp, g0);
        lin = up ? qc + slope : qc - slope;
        if (est <= qp || est >= qn) est = lin;
        est = clamp_height(qp, qn, est);
        diff = est - lin;
        blend = lin + (diff / 65536) * wt + ((diff % 65536) * wt) / 65536;
        q_h[k] = clamp_height(qp, qn, blend);
        q_pos[k] = up ? int'(pc + 1) : int'(pc - 1);
    endfunction

    // Advance the estimator state by one sample and return the expected result.
    function automatic quantile_result_t estimate_quantile(logic signed [31:0] smp);
        quantile_result_t r;
        longint hs, t, srt [5];
        longint unsigned p, ramp, w;
        int unsigned n, idx;
        int first;
        hs = longint'(smp) * 65536;
        p = (q_p > 65536) ? 65536 : q_p;
        if (q_count < 5) begin
            q_buf[q_count] = hs;
            q_count++;
            n = q_count;
            srt = q_buf;
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
                    t = srt[j]; srt[j] = srt[j-1]; srt[j-1] = t;
                end
            if (n < 5) begin
                idx = (p * (n - 1) + 32768) >> 16;
                if (idx > n - 1) idx = n - 1;
                r.est = srt[idx][H_W-1:0];
                r.warm = 1'b0;
                r.mmin = '0; r.mlow = '0; r.mhigh = '0; r.mmax = '0;
                return r;
            end
            for (int i = 0; i < 5; i++) begin
                q_h[i] = srt[i];
                q_pos[i] = i + 1;
            end
            q_des[0] = 64'd1 << 32;
            q_des[1] = (64'd1 << 32) + (p << 17);
            q_des[2] = (64'd1 << 32) + (p << 18);
            q_des[3] = (64'd1 << 32) + ((65536 + p) << 17);
            q_des[4] = 64'd5 << 32;
        end else begin
            ramp = (q_ramp == 0) ? 1 : q_ramp;
            if (q_count != 32'hFFFF_FFFF) q_count++;
            w = (longint'(q_count) << 16) / ramp;
            if (w > 65536) w = 65536;
            if (hs < q_h[0]) begin
                q_h[0] = hs;
                first = 1;
            end else if (hs < q_h[1]) first = 1;
            else if (hs < q_h[2]) first = 2;
            else if (hs < q_h[3]) first = 3;
            else if (hs < q_h[4]) first = 4;
            else begin
                q_h[4] = hs;
                first = 5;
            end
            for (int i = first; i < 5; i++)
                if (q_pos[i] != 32'hFFFF_FFFF) q_pos[i]++;
            q_des[1] = sat_sum(q_des[1], p << 15);
            q_des[2] = sat_sum(q_des[2], p << 16);
            q_des[3] = sat_sum(q_des[3], (65536 + p) << 15);
            q_des[4] = sat_sum(q_des[4], 64'd1 << 32);
            for (int k = 1; k <= 3; k++) move_marker(k, longint'(w));
        end
        r.est = q_h[2][H_W-1:0];
        r.warm = 1'b1;
        r.mmin = q_h[0][H_W-1:0];
        r.mlow = q_h[1][H_W-1:0];
        r.mhigh = q_h[3][H_W-1:0];
        r.mmax = q_h[4][H_W-1:0];
        return r;
    endfunction

    // Directed rows; a typed row replaces the predicted estimate.
    stim_row_t directed [$];
    int        row_ptr;

    // Append one directed row to the stimulus table.
    task automatic add_row(logic signed [31:0] smp, bit typed, logic [H_W-1:0] est);
        stim_row_t row;
        row.sample = smp;
        row.typed = typed;
        row.est = est;
        directed.insert(directed.size(), row);
    endtask

    // Predict on each accepted input and check each accepted result.
    always @(posedge aclk) begin
        quantile_result_t exp_r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                exp_r = estimate_quantile(s_sample);
                if (row_ptr < directed.size()) begin
                    if (directed[row_ptr].typed) exp_r.est = directed[row_ptr].est;
                    row_ptr++;
                end
                pending_results.insert(pending_results.size(), exp_r);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction, estimate %h", m_estimate);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_estimate !== exp_r.est) begin
                        $error("estimate: expected %h, got %h", exp_r.est, m_estimate);
                        errors++;
                    end
                    if (m_warmed_up !== exp_r.warm) begin
                        $error("warmed_up: expected %b, got %b", exp_r.warm, m_warmed_up);
                        errors++;
                    end
                    if (m_marker_min !== exp_r.mmin) begin
                        $error("marker_min: expected %h, got %h", exp_r.mmin, m_marker_min);
                        errors++;
                    end
                    if (m_marker_low !== exp_r.mlow) begin
                        $error("marker_low: expected %h, got %h", exp_r.mlow, m_marker_low);
                        errors++;
                    end
                    if (m_marker_high !== exp_r.mhigh) begin
                        $error("marker_high: expected %h, got %h", exp_r.mhigh,
                               m_marker_high);
                        errors++;
                    end
                    if (m_marker_max !== exp_r.mmax) begin
                        $error("marker_max: expected %h, got %h", exp_r.mmax, m_marker_max);
                        errors++;
                    end
                end
            end
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            m_ready <= 1'b0;
            hold_request <= hold_request - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(logic signed [31:0] smp);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Offer one register write; the caller drops cfg_valid after the last write.
    task automatic write_register(cfg_reg_t idx, logic [P_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_P_QUANTILE) q_p = val;
        else q_ramp = val[RAMP_W-1:0];
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly clustered samples around a center, with full-range noise and extremes.
    function automatic logic signed [31:0] random_sample(int center);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return center + int'($urandom_range(0, 4000)) - 2000;
        if (sel < 92) return $urandom;
        if (sel < 96) return 32'sh7FFF_FFFF;
        return 32'sh8000_0000;
    endfunction

    initial begin
        int center;
        logic [P_W-1:0] p_set [5];
        logic [P_W-1:0] ramp_set [5];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_P_QUANTILE;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        row_ptr = 0;
        hold_request = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        q_p = 32768;
        q_ramp = 100;
        q_count = 0;

        // Warm-up rows first: estimates are plain sorted buffer entries.
        add_row(32'sd7, 1'b1, 48'sd7 * 65536);
        add_row(32'sh8000_0000, 1'b1, 48'sd7 * 65536);
        add_row(32'sh7FFF_FFFF, 1'b0, '0);
        add_row(-32'sd1, 1'b0, '0);
        add_row(32'sd0, 1'b0, '0);
        // Past warm-up: equal values, new extremes and each marker interval.
        add_row(32'sd0, 1'b0, '0);
        add_row(32'sd0, 1'b0, '0);
        add_row(32'sh8000_0000, 1'b0, '0);
        add_row(32'sh7FFF_FFFF, 1'b0, '0);
        add_row(32'sd5, 1'b0, '0);
        add_row(-32'sd5, 1'b0, '0);
        add_row(32'sh4000_0000, 1'b0, '0);
        add_row(32'shC000_0000, 1'b0, '0);
        add_row(32'sh5555_5555, 1'b0, '0);
        add_row(32'shAAAA_AAAA, 1'b0, '0);
        add_row(32'sd100, 1'b0, '0);
        add_row(32'sd99, 1'b0, '0);
        add_row(32'sd101, 1'b0, '0);
        add_row(-32'sd100, 1'b0, '0);
        add_row(32'sd1, 1'b0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_sample(directed[i].sample);
        drain_results();

        // p of zero, one, above one and zero ramp among the settings.
        p_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd16384, 17'd32768};
        ramp_set = '{17'd1, 17'd65535, 17'd0, 17'd50, 17'd100};
        for (int ph = 0; ph < 5; ph++) begin
            write_register(REG_P_QUANTILE, (ph == 3) ? P_W'($urandom) : p_set[ph]);
            write_register(REG_WEIGHT_RAMP, ramp_set[ph]);
            cfg_valid <= 1'b0;
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 10;
                    hold_request = 3000;
                end
                2: begin
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                3: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            center = int'($urandom_range(0, 200000)) - 100000;
            for (int k = 0; k < 90; k++) begin
                if (k == 45) center = $urandom;
                send_sample(random_sample(center));
            end
            drain_results();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
